@@ hw/rtl/evl_pkg.sv @@
// Shared types, constants and character helpers for the environment lookup escaper.
`default_nettype none

package evl_pkg;

	// Name storage: eight bytes packed in one 64-bit register
	localparam int NAME_BYTES   = 8;
	localparam int MAX_NAME_LEN = 8;

	// Configuration port geometry
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam int LEN_W      = 4;

	// Register map, indexed by paddr[3]
	localparam logic REG_VAR_NAME     = 1'b0;
	localparam logic REG_VAR_NAME_LEN = 1'b1;

	// Characters
	localparam logic [7:0] CHAR_NUL       = 8'h00;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_PERCENT   = 8'h25;
	localparam logic [7:0] CHAR_EQ        = 8'h3D;
	localparam logic [7:0] CHAR_TILDE     = 8'h7E;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;	// 'A' - 10

	// Result slots of one input beat, emitted lowest first
	localparam int SLOT_SPACE = 0;
	localparam int SLOT_CHAR  = 1;
	localparam int SLOT_HEXHI = 2;
	localparam int SLOT_HEXLO = 3;
	localparam int SLOT_END   = 4;
	localparam int NUM_SLOTS  = 5;

	typedef enum logic [1:0] {
		MODE_SKIP    = 2'd0,
		MODE_MATCH   = 2'd1,
		MODE_COLLECT = 2'd2
	} evl_mode_t;

	// Results produced by one accepted input beat
	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic                 esc;
		logic [7:0]           env_byte;
		logic                 found;
	} evl_grp_t;

	// Bytes that pass through unescaped
	function automatic logic is_safe(input logic [7:0] c);
		logic ok;
		ok = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2F, 8'h3A, 8'h2E, 8'h40, 8'h2B, 8'h2D, 8'h5F, CHAR_TILDE,
			8'h5B, 8'h5D, 8'h2C};
		return ok;
	endfunction

	// Upper-case hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] d;
		if (v <= 4'd9) begin
			d = {4'h3, v};
		end else begin
			d = {4'h0, v} + HEX_ALPHA_BASE;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/evl_in_if.sv @@
// Input channel: one environment byte per beat.
`default_nettype none

interface evl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] env_byte;
	logic       buffer_end;

	modport source(output valid, output env_byte, output buffer_end, input ready);
	modport sink(input valid, input env_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/evl_out_if.sv @@
// Output channel: one escaped character or end marker per beat.
`default_nettype none

interface evl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       value_end;
	logic       found;

	modport source(output valid, output out_char, output char_valid,
		output value_end, output found, input ready);
	modport sink(input valid, input out_char, input char_valid,
		input value_end, input found, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/evl_cfg.sv @@
// APB register block: variable name and name length.
`default_nettype none

module evl_cfg
	import evl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [8*NAME_BYTES-1:0] var_name,
	output logic      [LEN_W-1:0]        var_name_length
);

	logic [8*NAME_BYTES-1:0] var_name_q;
	logic [LEN_W-1:0]        var_name_length_q;
	logic                    wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes; registers sit 8 bytes apart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_name_q        <= '0;
			var_name_length_q <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_VAR_NAME:     var_name_q        <= pwdata[8*NAME_BYTES-1:0];
				REG_VAR_NAME_LEN: var_name_length_q <= pwdata[LEN_W-1:0];
				default:          var_name_q        <= var_name_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[3])
			REG_VAR_NAME:     prdata = var_name_q;
			REG_VAR_NAME_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, var_name_length_q};
			default:          prdata = '0;
		endcase
	end

	assign var_name        = var_name_q;
	assign var_name_length = var_name_length_q;

endmodule

`default_nettype wire

@@ hw/rtl/evl_match.sv @@
// Name matcher: per-beat state update and result group decode.
`default_nettype none

module evl_match
	import evl_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [7:0]              env_byte,
	input  wire logic                    buffer_end,
	input  wire logic [8*NAME_BYTES-1:0] var_name,
	input  wire logic [LEN_W-1:0]        var_name_length,
	output evl_grp_t                     grp
);

	evl_mode_t        mode_q, mode_d;
	logic [LEN_W-1:0] name_pos_q, name_pos_d;
	logic             space_sent_q, space_sent_d;
	logic             value_done_q, value_done_d;
	logic [LEN_W-1:0] eff_len;
	logic [7:0]       name_sel;
	logic [7:0]       nc;

	// Expected name character at the current position, NUL past the end
	assign eff_len  = (var_name_length > LEN_W'(MAX_NAME_LEN)) ?
		LEN_W'(MAX_NAME_LEN) : var_name_length;
	assign name_sel = var_name[{name_pos_q[2:0], 3'b000} +: 8];
	assign nc       = (name_pos_q >= eff_len || name_pos_q >= LEN_W'(NAME_BYTES)) ?
		CHAR_NUL : name_sel;

	// Next state and the results this byte causes
	always_comb begin
		mode_d       = mode_q;
		name_pos_d   = name_pos_q;
		space_sent_d = space_sent_q;
		value_done_d = value_done_q;
		grp          = '0;
		grp.env_byte = env_byte;
		if (!value_done_q) begin
			case (mode_q)
				MODE_MATCH: begin
					if (env_byte == CHAR_NUL) begin
						name_pos_d = '0;
					end else if (nc == env_byte) begin
						name_pos_d = name_pos_q + LEN_W'(1);
					end else if (nc == CHAR_NUL && env_byte == CHAR_EQ) begin
						mode_d = MODE_COLLECT;
					end else begin
						mode_d = MODE_SKIP;
					end
				end
				MODE_COLLECT: begin
					if (env_byte == CHAR_NUL) begin
						value_done_d = 1'b1;
					end else begin
						if (!space_sent_q) begin
							grp.slots[SLOT_SPACE] = 1'b1;
							space_sent_d          = 1'b1;
						end
						if (is_safe(env_byte)) begin
							grp.slots[SLOT_CHAR] = 1'b1;
						end else begin
							grp.esc               = 1'b1;
							grp.slots[SLOT_CHAR]  = 1'b1;
							grp.slots[SLOT_HEXHI] = 1'b1;
							grp.slots[SLOT_HEXLO] = 1'b1;
						end
					end
				end
				default: begin
					// skipping, also the unused mode code
					if (env_byte == CHAR_NUL) begin
						name_pos_d = '0;
						mode_d     = MODE_MATCH;
					end
				end
			endcase
		end
		// End of buffer: end marker, then back to the reset state
		if (buffer_end) begin
			grp.slots[SLOT_END] = 1'b1;
			grp.found           = space_sent_d;
			mode_d              = MODE_MATCH;
			name_pos_d          = '0;
			space_sent_d        = 1'b0;
			value_done_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_MATCH;
			name_pos_q   <= '0;
			space_sent_q <= 1'b0;
			value_done_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			name_pos_q   <= name_pos_d;
			space_sent_q <= space_sent_d;
			value_done_q <= value_done_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/evl_emit.sv @@
// Result register and serializer: one output beat per pending slot.
`default_nettype none

module evl_emit
	import evl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire evl_grp_t grp,
	output logic          can_take,
	evl_out_if.source     res
);

	logic [NUM_SLOTS-1:0] slots_q;
	logic                 esc_q;
	logic [7:0]           byte_q;
	logic                 found_q;
	logic [NUM_SLOTS-1:0] cur;
	logic [NUM_SLOTS-1:0] rest;
	logic                 fire;

	// Lowest pending slot goes out first
	assign cur  = slots_q & (~slots_q + NUM_SLOTS'(1));
	assign rest = slots_q & ~cur;
	assign fire = res.valid && res.ready;

	// Free for a new group once the last pending beat leaves
	assign can_take = (rest == '0) && ((slots_q == '0) || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (load) begin
			slots_q <= grp.slots;
		end else if (fire) begin
			slots_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			esc_q   <= grp.esc;
			byte_q  <= grp.env_byte;
			found_q <= grp.found;
		end
	end

	// Output beat for the current slot
	always_comb begin
		res.valid      = |slots_q;
		res.out_char   = 8'h00;
		res.char_valid = 1'b0;
		res.value_end  = 1'b0;
		res.found      = 1'b0;
		case (1'b1)
			cur[SLOT_SPACE]: begin
				res.out_char   = CHAR_SPACE;
				res.char_valid = 1'b1;
			end
			cur[SLOT_CHAR]: begin
				res.out_char   = esc_q ? CHAR_PERCENT : byte_q;
				res.char_valid = 1'b1;
			end
			cur[SLOT_HEXHI]: begin
				res.out_char   = hex_digit(byte_q[7:4]);
				res.char_valid = 1'b1;
			end
			cur[SLOT_HEXLO]: begin
				res.out_char   = hex_digit(byte_q[3:0]);
				res.char_valid = 1'b1;
			end
			cur[SLOT_END]: begin
				res.value_end = 1'b1;
				res.found     = found_q;
			end
			default: begin
				res.out_char = 8'h00;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/env_var_lookup_url_escape.sv @@
// Top level: environment variable lookup with URL percent-encoding.
//
// env_in takes the environment block one byte per beat; buffer_end flags the
// last byte. esc_out gives the value of the entry named by var_name, each
// beat one character: a leading space, then each value byte as is or as
// '%' and two upper-case hex digits. The beat taking the last byte is
// followed by an end marker (value_end=1, found=1 if a value was emitted).
// An accepted byte shows its first result in the next cycle. A byte causes
// 0 to 5 output beats: 1 for a plain character, 3 for an escaped one, one
// more for the leading space or end marker. Bytes with no result are taken
// every cycle while no earlier result is pending. The serializer that
// drains one result group at a time sets this rate. A new byte is accepted
// in the cycle the last beat of the previous group leaves.
// A stalled receiver holds the current beat and, with it, the input.
// Reset clears the matcher, the pending results and both registers, which
// are written through the APB port at byte addresses 0 and 8.
`default_nettype none

module env_var_lookup_url_escape
	import evl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	evl_in_if.sink                     env_in,
	evl_out_if.source                  esc_out,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [8*NAME_BYTES-1:0] var_name;
	logic [LEN_W-1:0]        var_name_length;
	logic                    can_take;
	logic                    accept;
	evl_grp_t                grp;

	assign env_in.ready = can_take;
	assign accept       = env_in.valid && can_take;

	evl_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.var_name        (var_name),
		.var_name_length (var_name_length)
	);

	evl_match u_match (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.env_byte        (env_in.env_byte),
		.buffer_end      (env_in.buffer_end),
		.var_name        (var_name),
		.var_name_length (var_name_length),
		.grp             (grp)
	);

	evl_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.grp      (grp),
		.can_take (can_take),
		.res      (esc_out)
	);

	// The last byte of a buffer always leaves an end marker pending
	a_end_pending: assert property (@(posedge clk) disable iff (!arst_n)
		env_in.valid && env_in.ready && env_in.buffer_end |=> esc_out.valid)
	else $error("no result pending after last byte of buffer");

	// A stalled output beat blocks the input
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		esc_out.valid && !esc_out.ready |-> !env_in.ready)
	else $error("input taken while output stalled");

	// An end marker never carries a character
	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		esc_out.valid && esc_out.value_end |-> !esc_out.char_valid)
	else $error("end marker flagged as character");

endmodule

`default_nettype wire
